/* hw/rtl/roller_drive_anti_jam_macros.svh */
// ----------------------------------------------------------------------------
// Roller drive anti-jam assertion macros
// Shared concurrent assertion forms for the roller drive anti-jam block.
// ----------------------------------------------------------------------------
`ifndef ROLLER_DRIVE_ANTI_JAM_MACROS_SVH
`define ROLLER_DRIVE_ANTI_JAM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDAJ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("roller drive anti-jam: implication check failed");

// Next-cycle implication, checked outside reset.
`define RDAJ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("roller drive anti-jam: next-cycle check failed");

`endif

/* hw/rtl/rdaj_pkg.sv */
// ----------------------------------------------------------------------------
// Roller drive anti-jam package
// Types, command codes and register constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rdaj_pkg;

   // Command codes of the input transaction.
   localparam logic [2:0] CMD_CHECK = 3'd0;
   localparam logic [2:0] CMD_IN    = 3'd1;
   localparam logic [2:0] CMD_OUT   = 3'd2;
   localparam logic [2:0] CMD_STOP  = 3'd3;
   localparam logic [2:0] CMD_SPIN  = 3'd4;
   localparam logic [2:0] CMD_HOLD  = 3'd5;

   // Register indexes (byte address is four times the index).
   localparam logic [2:0] REG_DEFAULT_POWER   = 3'd0;
   localparam logic [2:0] REG_REVERSE_POWER   = 3'd1;
   localparam logic [2:0] REG_REVERSE_TIME_MS = 3'd2;
   localparam logic [2:0] REG_JAM_HOLD_MS     = 3'd3;
   localparam logic [2:0] REG_STALL_VELOCITY  = 3'd4;

   localparam int unsigned ADDR_WIDTH = 5;

   // Register reset values.
   localparam logic [6:0]  RST_DEFAULT_POWER   = 7'd127;
   localparam logic [6:0]  RST_REVERSE_POWER   = 7'd127;
   localparam logic [15:0] RST_REVERSE_TIME_MS = 16'd250;
   localparam logic [15:0] RST_JAM_HOLD_MS     = 16'd250;
   localparam logic [12:0] RST_STALL_VELOCITY  = 13'd50;

   // Most negative spin power is clamped to this value.
   localparam logic signed [7:0] POWER_MIN = -8'sd127;

   typedef struct packed {
      logic [6:0]  default_power;
      logic [6:0]  reverse_power;
      logic [15:0] reverse_time_ms;
      logic [15:0] jam_hold_ms;
      logic [12:0] stall_velocity;
   } cfg_type;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic signed [13:0] velocity;
      logic signed [7:0]  power;
      logic [2:0]         command;
   } item_type;

   typedef struct packed {
      logic              stalled;
      logic              jam_active;
      logic              brake_hold;
      logic signed [7:0] drive_power;
      logic              drive_valid;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/roller_drive_anti_jam.sv */
// ----------------------------------------------------------------------------
// Roller drive anti-jam
// Intake roller drive command handling with stall detection and jam reversal.
// ----------------------------------------------------------------------------
// Every request transaction produces exactly one response transaction, in the
// cycle after it is accepted. The block takes a new request whenever the
// response register is free; it is the only stage, so req_tready stays high
// while the response register is empty or being emptied, and the sustained
// rate is one transaction per cycle as long as the response side keeps
// rsp_tready high. Drive commands (in, out, stop, spin) record and issue a
// power, hold zeroes the recorded power and sets brake_hold, and a check
// transaction runs the stall timer and the reverse burst. Configuration
// registers are meant to be written while no transaction is in flight.
`default_nettype none

module roller_drive_anti_jam (
   input  wire                              clock,
   input  wire                              reset,
   // Request fields from bit 0 up: command[2:0], power[10:3],
   // velocity[24:11], now_ms[56:25], zero fill[63:57].
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [63:0]                      req_tdata,
   // Response fields from bit 0 up: drive_valid[0], drive_power[8:1],
   // brake_hold[9], jam_active[10], stalled[11], zero fill[15:12].
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [15:0]                      rsp_tdata,
   // Configuration port.
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [rdaj_pkg::ADDR_WIDTH-1:0]  csr_paddr,
   input  wire  [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   rdaj_pkg::cfg_type    cfg;
   rdaj_pkg::item_type   item;
   rdaj_pkg::result_type result;
   rdaj_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_accept;

   // Unpack the request transaction; the upper fill bits carry nothing.
   assign item.command  = req_tdata[2:0];
   assign item.power    = $signed(req_tdata[10:3]);
   assign item.velocity = $signed(req_tdata[24:11]);
   assign item.now_ms   = req_tdata[56:25];

   rdaj_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The core updates its state on the same edge that accepts the request.
   rdaj_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (req_accept),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   // A request may enter whenever the response register will be free.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The payload register needs no reset; it is only read while valid.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

`include "roller_drive_anti_jam_macros.svh"

   // Brake and a new drive power never come out of the same transaction.
   `RDAJ_ASSERT_IMPLY(a_brake_no_drive, clock, reset, rsp_valid_ff && rsp_data_ff.brake_hold, !rsp_data_ff.drive_valid && !rsp_data_ff.jam_active)
   // Without a drive power issued, the power field stays zero.
   `RDAJ_ASSERT_IMPLY(a_idle_power_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.drive_valid, rsp_data_ff.drive_power == 8'sd0)
   // A response waiting on a stalled sink holds its contents.
   `RDAJ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(rsp_data_ff))
   // An accepted request always shows up as a response in the next cycle.
   `RDAJ_ASSERT_NEXT(a_accept_to_rsp, clock, reset, req_accept, rsp_valid_ff)

endmodule

`default_nettype wire

/* hw/rtl/rdaj_csr.sv */
// ----------------------------------------------------------------------------
// Roller drive anti-jam register file
// APB-style configuration registers with zero wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module rdaj_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [rdaj_pkg::ADDR_WIDTH-1:0]    csr_paddr,
   input  wire  [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output rdaj_pkg::cfg_type                  cfg
);

   rdaj_pkg::cfg_type cfg_ff;
   rdaj_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[rdaj_pkg::ADDR_WIDTH-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rdaj_pkg::REG_DEFAULT_POWER:   cfg_in.default_power   = csr_pwdata[6:0];
            rdaj_pkg::REG_REVERSE_POWER:   cfg_in.reverse_power   = csr_pwdata[6:0];
            rdaj_pkg::REG_REVERSE_TIME_MS: cfg_in.reverse_time_ms = csr_pwdata[15:0];
            rdaj_pkg::REG_JAM_HOLD_MS:     cfg_in.jam_hold_ms     = csr_pwdata[15:0];
            rdaj_pkg::REG_STALL_VELOCITY:  cfg_in.stall_velocity  = csr_pwdata[12:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_power   <= rdaj_pkg::RST_DEFAULT_POWER;
         cfg_ff.reverse_power   <= rdaj_pkg::RST_REVERSE_POWER;
         cfg_ff.reverse_time_ms <= rdaj_pkg::RST_REVERSE_TIME_MS;
         cfg_ff.jam_hold_ms     <= rdaj_pkg::RST_JAM_HOLD_MS;
         cfg_ff.stall_velocity  <= rdaj_pkg::RST_STALL_VELOCITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         rdaj_pkg::REG_DEFAULT_POWER:   csr_prdata = {25'd0, cfg_ff.default_power};
         rdaj_pkg::REG_REVERSE_POWER:   csr_prdata = {25'd0, cfg_ff.reverse_power};
         rdaj_pkg::REG_REVERSE_TIME_MS: csr_prdata = {16'd0, cfg_ff.reverse_time_ms};
         rdaj_pkg::REG_JAM_HOLD_MS:     csr_prdata = {16'd0, cfg_ff.jam_hold_ms};
         rdaj_pkg::REG_STALL_VELOCITY:  csr_prdata = {19'd0, cfg_ff.stall_velocity};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/rdaj_core.sv */
// ----------------------------------------------------------------------------
// Roller drive anti-jam core
// Drive state, stall timer and reverse burst logic, one transaction a cycle when stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module rdaj_core (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step,
   input  rdaj_pkg::item_type       item,
   input  rdaj_pkg::cfg_type        cfg,
   output rdaj_pkg::result_type     result
);

   logic signed [7:0] commanded_power_ff, commanded_power_in;
   logic              clearing_ff, clearing_in;
   logic [31:0]       stall_start_ms_ff, stall_start_ms_in;
   logic [31:0]       burst_end_ms_ff, burst_end_ms_in;

   logic [13:0]       vel_mag;
   logic              stall;
   logic [31:0]       stall_elapsed;
   logic [31:0]       burst_end_new;
   logic signed [7:0] fwd_power;
   logic signed [7:0] rev_power;
   logic signed [7:0] spin_power;

   // Magnitude of the most negative velocity still fits as unsigned 14 bits.
   assign vel_mag       = item.velocity[13] ? 14'(-item.velocity) : item.velocity;
   assign stall         = vel_mag < {1'b0, cfg.stall_velocity};
   assign stall_elapsed = item.now_ms - stall_start_ms_ff;
   assign burst_end_new = item.now_ms + {16'd0, cfg.reverse_time_ms};
   assign fwd_power     = $signed({1'b0, cfg.default_power});
   assign rev_power     = $signed({1'b0, cfg.reverse_power});
   assign spin_power    = (item.power < rdaj_pkg::POWER_MIN) ? rdaj_pkg::POWER_MIN
                                                             : item.power;

   always_comb begin
      commanded_power_in = commanded_power_ff;
      clearing_in        = clearing_ff;
      stall_start_ms_in  = stall_start_ms_ff;
      burst_end_ms_in    = burst_end_ms_ff;
      result             = '0;
      result.stalled     = stall;

      case (item.command)
         rdaj_pkg::CMD_CHECK: begin
            if (commanded_power_ff == 8'sd0) begin
               clearing_in       = 1'b0;
               stall_start_ms_in = 32'd0;
            end else if (clearing_ff) begin
               if (item.now_ms < burst_end_ms_ff) begin
                  result.jam_active = 1'b1;
               end else begin
                  clearing_in        = 1'b0;
                  stall_start_ms_in  = 32'd0;
                  result.drive_valid = 1'b1;
                  result.drive_power = commanded_power_ff;
               end
            end else if (stall) begin
               // A start time of zero means no stall is being timed.
               if (stall_start_ms_ff == 32'd0) begin
                  stall_start_ms_in = item.now_ms;
               end else if (stall_elapsed > {16'd0, cfg.jam_hold_ms}) begin
                  result.drive_valid = 1'b1;
                  result.drive_power = (commanded_power_ff > 8'sd0) ? -rev_power
                                                                    : rev_power;
                  result.jam_active  = 1'b1;
                  clearing_in        = 1'b1;
                  burst_end_ms_in    = burst_end_new;
               end
            end else begin
               stall_start_ms_in = 32'd0;
            end
         end
         rdaj_pkg::CMD_IN: begin
            commanded_power_in = fwd_power;
            result.drive_valid = 1'b1;
            result.drive_power = fwd_power;
         end
         rdaj_pkg::CMD_OUT: begin
            commanded_power_in = -fwd_power;
            result.drive_valid = 1'b1;
            result.drive_power = -fwd_power;
         end
         rdaj_pkg::CMD_STOP: begin
            commanded_power_in = 8'sd0;
            result.drive_valid = 1'b1;
         end
         rdaj_pkg::CMD_SPIN: begin
            commanded_power_in = spin_power;
            result.drive_valid = 1'b1;
            result.drive_power = spin_power;
         end
         rdaj_pkg::CMD_HOLD: begin
            commanded_power_in = 8'sd0;
            result.brake_hold  = 1'b1;
         end
         default: begin
            commanded_power_in = commanded_power_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         commanded_power_ff <= 8'sd0;
         clearing_ff        <= 1'b0;
         stall_start_ms_ff  <= 32'd0;
         burst_end_ms_ff    <= 32'd0;
      end else if (step) begin
         commanded_power_ff <= commanded_power_in;
         clearing_ff        <= clearing_in;
         stall_start_ms_ff  <= stall_start_ms_in;
         burst_end_ms_ff    <= burst_end_ms_in;
      end
   end

endmodule

`default_nettype wire
